### src/tcw_pkg.sv
package tcw_pkg;

   localparam int unsigned COLUMNS_DEFAULT = 80;
   localparam int unsigned ROWS_DEFAULT    = 25;

   localparam int unsigned CELL_W     = 16;
   localparam int unsigned CSR_ADDR_W = 3;

   localparam logic [7:0] NEWLINE_CODE   = 8'h0A;
   localparam logic [7:0] SPACE_CODE     = 8'h20;
   localparam logic [7:0] ATTRIBUTE_INIT = 8'h07;

   // register index, taken from paddr[2]
   localparam logic REG_CELL_ATTRIBUTE = 1'b0;

   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] char_code;
      logic [4:0] read_row;
      logic [6:0] read_column;
   } req_type;

   typedef struct packed {
      logic [15:0] cell_word;
      logic [4:0]  cursor_row;
      logic [6:0]  cursor_column;
      logic        scrolled;
   } rsp_type;

endpackage

### src/tcw_cell_ram.sv
module tcw_cell_ram #(
   parameter int unsigned DEPTH = 2000
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [tcw_pkg::CELL_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [tcw_pkg::CELL_W-1:0] rd_data
);
   import tcw_pkg::*;

   logic [CELL_W-1:0] mem_ff [DEPTH];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/text_console_writer.sv
// Channel   Direction  Handshake                 Payload
// request   in         req_valid / req_stall     req_data  (tcw_pkg::req_type)
// response  out        rsp_valid / rsp_stall     rsp_data  (tcw_pkg::rsp_type)
// csr       in/out     psel penable pwrite pready paddr pwdata prdata (APB-style)
//
// A plain write or unused action answers from idle; a read answers via ST_FINISH; a clear
// blanks every cell first. A scrolling write copies with read-ahead, then blanks the bottom
// row, per scroll; on the bottom row a pending wrap followed by a newline scrolls twice.
// Reset (synchronous) homes the cursor, sets the attribute to 7 and empties the response
// register; cell contents are left as they are.
// One request at a time; a stalled response holds and the next request enters as it leaves.
module text_console_writer #(
   parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int unsigned ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_stall,
   input  tcw_pkg::req_type               req_data,

   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output tcw_pkg::rsp_type               rsp_data,

   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [tcw_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);
   import tcw_pkg::*;

   localparam int unsigned CELLS  = ROWS * COLUMNS;
   localparam int unsigned ADDR_W = $clog2(CELLS);
   localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int unsigned COL_W  = $clog2(COLUMNS + 1);   // holds COLUMNS (wrap pending)
   localparam int unsigned SUM_W  = ROW_W + 2;

   localparam logic [ADDR_W-1:0] COPY_LAST  = ADDR_W'(CELLS - COLUMNS - 1);
   localparam logic [ADDR_W-1:0] CELL_LAST  = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);
   localparam logic [ADDR_W-1:0] AHEAD_NEXT = ADDR_W'(COLUMNS + 1);
   localparam logic [COL_W-1:0]  COL_WRAP   = COL_W'(COLUMNS);
   localparam logic [SUM_W-1:0]  LAST_ROW_X = SUM_W'(ROWS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRIME,    // first read of a scroll copy
      ST_COPY,     // cell[p] <= cell[p + COLUMNS], next read issued ahead
      ST_BLANK,    // blank sweep: bottom row on scroll, whole screen on clear
      ST_PUT,      // character held back until the scrolls are done
      ST_FINISH
   } state_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
      return ADDR_W'(r) * ROW_STRIDE + ADDR_W'(c);
   endfunction

   state_type         state_ff, state_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [7:0]        attr_ff, attr_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic [1:0]        scroll_cnt_ff, scroll_cnt_in;
   logic              clear_ff, clear_in;
   logic              scrolled_ff, scrolled_in;
   logic              is_read_ff, is_read_in;
   logic              hit_ff, hit_in;
   logic              pend_we_ff, pend_we_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic [CELL_W-1:0] pend_data_ff, pend_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [CELL_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [CELL_W-1:0] rd_data;

   logic              accept;
   logic              rsp_free;
   logic              csr_write;
   logic [CELL_W-1:0] blank_word;

   // write-character decode
   logic              wrap;
   logic              is_nl;
   logic [SUM_W-1:0]  row_sum;
   logic [1:0]        scrolls;
   logic [ROW_W-1:0]  final_row;
   logic [COL_W-1:0]  col_base;
   logic [COL_W-1:0]  final_col;

   tcw_cell_ram #(
      .DEPTH(CELLS)
   ) u_cells (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // csr
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == REG_CELL_ATTRIBUTE) ? {24'd0, attr_ff} : 32'd0;

   assign blank_word = {attr_ff, SPACE_CODE};
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == ST_IDLE) && rsp_free);
   assign accept     = req_valid && !req_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Lazy wrap: a pending wrap and a newline byte each advance a line;
   // every advance past the bottom row costs one scroll.
   always_comb begin
      wrap      = (col_ff == COL_WRAP);
      is_nl     = (req_data.char_code == NEWLINE_CODE);
      row_sum   = SUM_W'(row_ff) + SUM_W'(wrap) + SUM_W'(is_nl);
      if (row_sum > LAST_ROW_X) begin
         scrolls   = 2'(row_sum - LAST_ROW_X);
         final_row = ROW_W'(LAST_ROW_X);
      end else begin
         scrolls   = 2'd0;
         final_row = ROW_W'(row_sum);
      end
      col_base  = wrap ? '0 : col_ff;
      final_col = is_nl ? '0 : col_base + COL_W'(1);
   end

   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      attr_in       = attr_ff;
      ptr_in        = ptr_ff;
      scroll_cnt_in = scroll_cnt_ff;
      clear_in      = clear_ff;
      scrolled_in   = scrolled_ff;
      is_read_in    = is_read_ff;
      hit_in        = hit_ff;
      pend_we_in    = pend_we_ff;
      pend_addr_in  = pend_addr_ff;
      pend_data_in  = pend_data_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      wr_en   = 1'b0;
      wr_addr = ptr_ff;
      wr_data = blank_word;
      rd_en   = 1'b0;
      rd_addr = ptr_ff + ROW_STRIDE;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write && (paddr[2] == REG_CELL_ATTRIBUTE)) begin
         attr_in = pwdata[7:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               is_read_in  = 1'b0;
               scrolled_in = 1'b0;
               case (req_data.action)
                  ACT_CLEAR: begin
                     row_in   = '0;
                     col_in   = '0;
                     ptr_in   = '0;
                     clear_in = 1'b1;
                     state_in = ST_BLANK;
                  end
                  ACT_WRITE: begin
                     row_in = final_row;
                     col_in = final_col;
                     if (scrolls == 2'd0) begin
                        wr_en        = !is_nl;
                        wr_addr      = cell_addr(final_row, col_base);
                        wr_data      = {attr_ff, req_data.char_code};
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '{cell_word:     16'd0,
                                         cursor_row:    5'(final_row),
                                         cursor_column: 7'(final_col),
                                         scrolled:      1'b0};
                     end else begin
                        scroll_cnt_in = scrolls;
                        pend_we_in    = !is_nl;
                        pend_addr_in  = cell_addr(final_row, col_base);
                        pend_data_in  = {attr_ff, req_data.char_code};
                        clear_in      = 1'b0;
                        scrolled_in   = 1'b1;
                        ptr_in        = '0;
                        state_in      = ST_PRIME;
                     end
                  end
                  ACT_READ: begin
                     hit_in     = (32'(req_data.read_row) < ROWS) &&
                                  (32'(req_data.read_column) < COLUMNS);
                     rd_en      = 1'b1;
                     rd_addr    = cell_addr(ROW_W'(req_data.read_row),
                                            COL_W'(req_data.read_column));
                     is_read_in = 1'b1;
                     state_in   = ST_FINISH;
                  end
                  default: begin
                     // unused action: no state change
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '{cell_word:     16'd0,
                                      cursor_row:    5'(row_ff),
                                      cursor_column: 7'(col_ff),
                                      scrolled:      1'b0};
                  end
               endcase
            end
         end
         ST_PRIME: begin
            rd_en    = 1'b1;
            rd_addr  = ptr_ff + ROW_STRIDE;
            state_in = ST_COPY;
         end
         ST_COPY: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = rd_data;
            ptr_in  = ptr_ff + ADDR_W'(1);
            if (ptr_ff == COPY_LAST) begin
               state_in = ST_BLANK;
            end else begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff + AHEAD_NEXT;
            end
         end
         ST_BLANK: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = blank_word;
            if (ptr_ff == CELL_LAST) begin
               ptr_in = '0;
               if (clear_ff) begin
                  state_in = ST_FINISH;
               end else if (scroll_cnt_ff == 2'd1) begin
                  state_in = ST_PUT;
               end else begin
                  scroll_cnt_in = scroll_cnt_ff - 2'd1;
                  state_in      = ST_PRIME;
               end
            end else begin
               ptr_in = ptr_ff + ADDR_W'(1);
            end
         end
         ST_PUT: begin
            wr_en    = pend_we_ff;
            wr_addr  = pend_addr_ff;
            wr_data  = pend_data_ff;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{cell_word:     (is_read_ff && hit_ff) ? rd_data : 16'd0,
                                cursor_row:    5'(row_ff),
                                cursor_column: 7'(col_ff),
                                scrolled:      scrolled_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         attr_ff      <= ATTRIBUTE_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         attr_ff      <= attr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff        <= ptr_in;
      scroll_cnt_ff <= scroll_cnt_in;
      clear_ff      <= clear_in;
      scrolled_ff   <= scrolled_in;
      is_read_ff    <= is_read_in;
      hit_ff        <= hit_in;
      pend_we_ff    <= pend_we_in;
      pend_addr_ff  <= pend_addr_in;
      pend_data_ff  <= pend_data_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

### tb/console_screen_checker.sv
`timescale 1ns / 100ps
module console_screen_checker #(
   parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int unsigned ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  tcw_pkg::req_type               req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  tcw_pkg::rsp_type               rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [tcw_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   input  logic                           pready,
   output int                             fail_count,
   output int                             awaited_count
);
   import tcw_pkg::*;

   localparam int unsigned CELLS = COLUMNS * ROWS;

   logic [CELL_W-1:0] screen_copy [CELLS];
   int unsigned       cur_row;
   int unsigned       cur_col;
   logic [7:0]        attr_byte;
   rsp_type           screen_replies_q [$];

   initial fail_count = 0;

   function automatic logic [CELL_W-1:0] blank_word();
      return {attr_byte, SPACE_CODE};
   endfunction

   // newline; on the bottom row the screen moves up one line
   task automatic line_feed(inout logic rolled);
      cur_col = 0;
      if (cur_row + 1 >= ROWS) begin
         for (int i = 0; i < CELLS - COLUMNS; i++) screen_copy[i] = screen_copy[i + COLUMNS];
         for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_copy[i] = blank_word();
         cur_row = ROWS - 1;
         rolled  = 1'b1;
      end else begin
         cur_row++;
      end
   endtask

   task automatic predict_reply(input req_type rq, output rsp_type rs);
      logic        rolled;
      int unsigned spot;
      rolled = 1'b0;
      rs     = '0;
      case (rq.action)
         ACT_CLEAR: begin
            for (int i = 0; i < CELLS; i++) screen_copy[i] = blank_word();
            cur_row = 0;
            cur_col = 0;
         end
         ACT_WRITE: begin
            // lazy wrap: a pending wrap is taken before the byte
            if (cur_col >= COLUMNS) line_feed(rolled);
            if (rq.char_code == NEWLINE_CODE) begin
               line_feed(rolled);
            end else begin
               spot = cur_row * COLUMNS + cur_col;
               if (spot < CELLS) screen_copy[spot] = {attr_byte, rq.char_code};
               cur_col++;
            end
         end
         ACT_READ: begin
            if (rq.read_row < ROWS && rq.read_column < COLUMNS)
               rs.cell_word = screen_copy[rq.read_row * COLUMNS + rq.read_column];
         end
         default: ;
      endcase
      rs.cursor_row    = cur_row[4:0];
      rs.cursor_column = cur_col[6:0];
      rs.scrolled      = rolled;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type made;
      if (reset) begin
         cur_row   = 0;
         cur_col   = 0;
         attr_byte = ATTRIBUTE_INIT;
         screen_replies_q.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr[2] == REG_CELL_ATTRIBUTE)
            attr_byte = pwdata[7:0];
         if (rsp_valid && !rsp_stall) begin
            if (screen_replies_q.size() == 0) begin
               $error("response with no request outstanding: %h", rsp_data);
               fail_count++;
            end else begin
               want = screen_replies_q.pop_front();
               if (rsp_data.cell_word !== want.cell_word) begin
                  $error("cell_word expected %h actual %h", want.cell_word, rsp_data.cell_word);
                  fail_count++;
               end
               if (rsp_data.cursor_row !== want.cursor_row) begin
                  $error("cursor_row expected %0d actual %0d",
                         want.cursor_row, rsp_data.cursor_row);
                  fail_count++;
               end
               if (rsp_data.cursor_column !== want.cursor_column) begin
                  $error("cursor_column expected %0d actual %0d",
                         want.cursor_column, rsp_data.cursor_column);
                  fail_count++;
               end
               if (rsp_data.scrolled !== want.scrolled) begin
                  $error("scrolled expected %b actual %b", want.scrolled, rsp_data.scrolled);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_reply(req_data, made);
            screen_replies_q.push_back(made);
         end
      end
      awaited_count = screen_replies_q.size();
   end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
   import tcw_pkg::*;

   localparam int unsigned COLUMNS    = COLUMNS_DEFAULT;
   localparam int unsigned ROWS       = ROWS_DEFAULT;
   localparam int          ITEM_GOAL  = 800;
   localparam int          PHASES     = 5;
   // the fourth action code has no meaning; the block must ignore it
   localparam logic [1:0]  ACT_UNUSED = 2'd3;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [31:0]           pwdata    = '0;
   logic [31:0]           prdata;
   logic                  pready;

   int          fail_count;
   int          awaited_count;
   // stimulus-side copy of the cursor column, only used to aim at the right edge
   int unsigned track_col   = 0;
   int          items_sent  = 0;
   bit          quiet_req   = 1'b0;
   int          stall_hold  = 0;

   always #5 clock = ~clock;

   text_console_writer #(.COLUMNS(COLUMNS), .ROWS(ROWS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   console_screen_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) screen_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .pready        (pready),
      .fail_count    (fail_count),
      .awaited_count (awaited_count)
   );

   // Response back-pressure: runs of stall and free cycles. Stall runs are
   // mostly short with the odd long one; every so often a long free stretch.
   always @(negedge clock) begin
      int pick;
      pick = $urandom_range(0, 99);
      if (stall_hold > 0) begin
         stall_hold--;
      end else if (rsp_stall) begin
         rsp_stall  = 1'b0;
         stall_hold = (pick < 10) ? $urandom_range(100, 300) : $urandom_range(0, 12);
      end else begin
         rsp_stall  = 1'b1;
         stall_hold = (pick < 8) ? $urandom_range(15, 50) : $urandom_range(0, 3);
      end
   end

   // Idle cycles ahead of a request: mostly none or short, a few long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_req) return 0;
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic req_type build_request(input logic [1:0] act, input logic [7:0] code,
                                             input logic [4:0] row, input logic [6:0] col);
      req_type rq;
      rq.action      = act;
      rq.char_code   = code;
      rq.read_row    = row;
      rq.read_column = col;
      return rq;
   endfunction

   // Drive one request at the falling edge and hold it until the block takes
   // it. Valid stays high into the next request when no gap follows.
   task automatic push_request(input req_type item);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
      // keep the column copy in step so edge-filling bursts land exactly
      if (item.action == ACT_CLEAR) begin
         track_col = 0;
      end else if (item.action == ACT_WRITE) begin
         if (track_col >= COLUMNS) track_col = 0;
         if (item.char_code == NEWLINE_CODE) track_col = 0;
         else track_col++;
      end
      if (item.action != ACT_UNUSED) items_sent++;
   endtask

   // Attribute writes happen only with the block drained: every request
   // has its response, so a few extra cycles are plenty.
   task automatic set_attribute(input logic [7:0] value);
      req_valid = 1'b0;
      wait (awaited_count == 0);
      repeat (4) @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {REG_CELL_ATTRIBUTE, 2'b00};
      pwdata  = {24'h0, value};
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   function automatic logic [7:0] text_byte();
      logic [7:0] code;
      code = 8'($urandom_range(0, 255));
      if (code == NEWLINE_CODE) code = SPACE_CODE;
      return code;
   endfunction

   // Read address: mostly on-screen, sometimes anywhere the fields reach.
   function automatic req_type random_read();
      if ($urandom_range(0, 99) < 85)
         return build_request(ACT_READ, 8'($urandom_range(0, 255)),
                              5'($urandom_range(0, ROWS - 1)),
                              7'($urandom_range(0, COLUMNS - 1)));
      return build_request(ACT_READ, 8'($urandom_range(0, 255)),
                           5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
   endfunction

   initial begin
      logic [7:0] phase_attr [PHASES];
      int         mode;
      int         n;
      int         target;

      phase_attr[0] = 8'h00;
      phase_attr[1] = 8'hFF;
      phase_attr[2] = 8'($urandom_range(0, 255));
      phase_attr[3] = 8'($urandom_range(0, 255));
      phase_attr[4] = 8'h80;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // ---- directed part, reset attribute ----
      // Before the first clear only cells written here may be read back.
      push_request(build_request(ACT_WRITE, 8'h41, 5'd0, 7'd0));
      push_request(build_request(ACT_WRITE, 8'hFF, 5'd31, 7'd127));
      push_request(build_request(ACT_WRITE, 8'h00, 5'd0, 7'd0));
      push_request(build_request(ACT_READ, 8'h00, 5'd0, 7'd0));
      push_request(build_request(ACT_READ, 8'hFF, 5'd0, 7'd1));
      push_request(build_request(ACT_READ, 8'h00, 5'd0, 7'd2));
      // reads past the screen edge answer zero and touch no cell
      push_request(build_request(ACT_READ, 8'h00, 5'd31, 7'd0));
      push_request(build_request(ACT_READ, 8'h00, 5'd0, 7'd127));
      push_request(build_request(ACT_READ, 8'h00, 5'd25, 7'd80));
      // unused action with every field bit set: state must not move
      push_request(build_request(ACT_UNUSED, 8'hFF, 5'd31, 7'd127));
      push_request(build_request(ACT_CLEAR, 8'hFF, 5'd31, 7'd127));
      push_request(build_request(ACT_READ, 8'h00, 5'(ROWS - 1), 7'(COLUMNS - 1)));
      push_request(build_request(ACT_READ, 8'h00, 5'd0, 7'd0));
      push_request(build_request(ACT_WRITE, NEWLINE_CODE, 5'd0, 7'd0));
      push_request(build_request(ACT_WRITE, 8'h7E, 5'd0, 7'd0));

      set_attribute(8'hFF);
      push_request(build_request(ACT_WRITE, 8'h5A, 5'd0, 7'd0));
      push_request(build_request(ACT_READ, 8'h00, 5'd1, 7'd0));
      push_request(build_request(ACT_READ, 8'h00, 5'd1, 7'd1));
      push_request(build_request(ACT_CLEAR, 8'h00, 5'd0, 7'd0));
      push_request(build_request(ACT_READ, 8'h00, 5'd12, 7'd40));

      // ---- random part, in attribute phases ----
      for (int p = 0; p < PHASES; p++) begin
         set_attribute(phase_attr[p]);
         target = items_sent + ITEM_GOAL / PHASES;
         while (items_sent < target) begin
            quiet_req = ($urandom_range(0, 4) == 0);
            mode      = $urandom_range(0, 99);
            if (mode < 35) begin
               // a line of text, often ended by a newline
               n = $urandom_range(1, 30);
               repeat (n) push_request(build_request(ACT_WRITE, 8'($urandom_range(0, 255)),
                                                     5'($urandom_range(0, 31)),
                                                     7'($urandom_range(0, 127))));
               if ($urandom_range(0, 99) < 40)
                  push_request(build_request(ACT_WRITE, NEWLINE_CODE, 5'd0, 7'd0));
            end else if (mode < 45) begin
               // run the cursor to the right edge, then hit the pending wrap
               // with a newline (double line feed), a byte, or a read
               n = COLUMNS - track_col;
               repeat (n) push_request(build_request(ACT_WRITE, text_byte(), 5'd0, 7'd0));
               n = $urandom_range(0, 99);
               if (n < 40) push_request(build_request(ACT_WRITE, NEWLINE_CODE, 5'd0, 7'd0));
               else if (n < 75) push_request(build_request(ACT_WRITE, text_byte(), 5'd0, 7'd0));
               else push_request(random_read());
            end else if (mode < 65) begin
               n = $urandom_range(1, 6);
               repeat (n) push_request(random_read());
            end else if (mode < 80) begin
               // newline runs push the cursor down and, once at the bottom, scroll
               n = $urandom_range(1, 10);
               repeat (n) push_request(build_request(ACT_WRITE, NEWLINE_CODE,
                                                     5'($urandom_range(0, 31)),
                                                     7'($urandom_range(0, 127))));
            end else if (mode < 83) begin
               push_request(build_request(ACT_CLEAR, 8'($urandom_range(0, 255)),
                                          5'($urandom_range(0, 31)),
                                          7'($urandom_range(0, 127))));
            end else begin
               // noise: any non-clear action with every field random
               n = $urandom_range(1, 10);
               repeat (n) push_request(build_request(2'($urandom_range(1, 3)),
                                                     8'($urandom_range(0, 255)),
                                                     5'($urandom_range(0, 31)),
                                                     7'($urandom_range(0, 127))));
            end
         end
      end

      // ---- drain and verdict ----
      req_valid = 1'b0;
      wait (awaited_count == 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog, sized for every request paying two full scrolls plus the
   // longest gaps and stalls, with a wide margin.
   initial begin
      #500_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
